@@ rtl/prq_pkg.sv @@
// Shared constants, word types and codes of the priority request queue.
`default_nettype none

package prq_pkg;

   localparam int NUM_LEVELS    = 4;
   localparam int LEVEL_DEPTH   = 4;
   localparam int HANDLE_BITS   = 8;
   localparam int TOTAL_ENTRIES = NUM_LEVELS * LEVEL_DEPTH;

   localparam int LEVEL_BITS = $clog2(NUM_LEVELS);
   localparam int POS_BITS   = $clog2(LEVEL_DEPTH);
   localparam int COUNT_BITS = $clog2(LEVEL_DEPTH + 1);
   localparam int STEP_BITS  = $clog2(NUM_LEVELS + 1);
   localparam int ADDR_BITS  = $clog2(TOTAL_ENTRIES);

   typedef enum logic [1:0] {
      CMD_ENQUEUE = 2'd0,
      CMD_REMOVE  = 2'd1,
      CMD_UPDATE  = 2'd2,
      CMD_SELECT  = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      STS_DONE       = 2'd0,
      STS_LEVEL_FULL = 2'd1,
      STS_NOT_FOUND  = 2'd2,
      STS_NONE_READY = 2'd3
   } status_type;

   typedef struct packed {
      cmd_type    command;
      logic [7:0] handle;
      logic [1:0] priority_req;
      logic       has_file;
      logic       in_progress;
      logic       wants_data;
      logic [1:0] buffers_filled;
   } req_word_type;

   typedef struct packed {
      status_type status;
      logic [7:0] selected_handle;
      logic [1:0] selected_level;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0] buffers_filled;
      logic       wants_data;
      logic       in_progress;
      logic       has_file;
   } flags_type;

   typedef struct packed {
      flags_type              flags;
      logic [HANDLE_BITS-1:0] handle;
   } entry_type;

endpackage

`default_nettype wire

@@ rtl/prq_if.sv @@
// Valid/ready channel interfaces for request and response words.
`default_nettype none

interface prq_req_if;
   import prq_pkg::*;
   logic         valid;
   logic         ready;
   req_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

interface prq_rsp_if;
   import prq_pkg::*;
   logic         valid;
   logic         ready;
   rsp_word_type word;
   modport source (output valid, output word, input ready);
   modport sink (input valid, input word, output ready);
endinterface

`default_nettype wire

@@ rtl/priority_request_queue.sv @@
// Multi-level priority queue of request handles with eligibility flags.
//
// Usage: commands arrive as words on req_port (enqueue, remove, update flags,
// select next eligible) and each gives exactly one response word on rsp_port
// carrying a status, and for select the chosen handle and its level.
// Entries sit in one synchronous memory of NUM_LEVELS * LEVEL_DEPTH words with
// a registered read port; per-level fill counts sit in flip-flops.
// One command is worked on at a time; req_port.ready is high while idle.
// Enqueue: ST_ENQ writes the entry unless the level is full; ST_FINISH responds.
// Remove, update, select: a pipelined scan reads one stored entry per cycle
// and steps to the next level once a level is read out; remove then closes
// the gap by reading each following entry in ST_SH_RD and writing it one slot
// lower in ST_SH_WR. The memory read port and the single scan pointer set the
// pace of a search.
// Reset empties every level at once; memory contents are not cleared.
// A response word waits in an output register; the next command is taken
// while it waits, and its own response holds until the register is free.
`default_nettype none

module priority_request_queue (
   input  wire logic clock,
   input  wire logic reset,
   prq_req_if.sink   req_port,
   prq_rsp_if.source rsp_port
);
   import prq_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE   = 6'b000001,
      ST_ENQ    = 6'b000010,
      ST_SCAN   = 6'b000100,
      ST_SH_RD  = 6'b001000,
      ST_SH_WR  = 6'b010000,
      ST_FINISH = 6'b100000
   } state_type;

   entry_type entry_mem [TOTAL_ENTRIES];

   state_type state_ff, state_in;
   logic [COUNT_BITS-1:0] level_count_ff [NUM_LEVELS];

   cmd_type                op_cmd_ff, op_cmd_in;
   logic [HANDLE_BITS-1:0] op_handle_ff, op_handle_in;
   logic [LEVEL_BITS-1:0]  op_level_ff, op_level_in;
   flags_type              op_flags_ff, op_flags_in;

   logic [STEP_BITS-1:0]  scan_k_ff, scan_k_in;
   logic [COUNT_BITS-1:0] scan_j_ff, scan_j_in;
   logic                  rd_valid_ff, rd_valid_in;
   logic [LEVEL_BITS-1:0] rd_lvl_ff, rd_lvl_in;
   logic [POS_BITS-1:0]   rd_pos_ff, rd_pos_in;
   entry_type             rd_word_ff;

   logic [LEVEL_BITS-1:0] shift_lvl_ff, shift_lvl_in;
   logic [POS_BITS-1:0]   shift_pos_ff, shift_pos_in;

   status_type            res_status_ff, res_status_in;
   logic [7:0]            res_handle_ff, res_handle_in;
   logic [1:0]            res_level_ff, res_level_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;

   logic                  mem_we;
   logic [ADDR_BITS-1:0]  mem_waddr;
   entry_type             mem_wdata;
   logic [ADDR_BITS-1:0]  mem_raddr;

   logic                  count_we;
   logic [COUNT_BITS-1:0] count_wdata;
   logic [LEVEL_BITS-1:0] cur_lvl;
   logic [COUNT_BITS-1:0] cur_count;

   logic                  scan_up;
   logic [LEVEL_BITS-1:0] scan_lvl;
   logic [COUNT_BITS-1:0] scan_down_pos;
   logic [POS_BITS-1:0]   scan_pos;
   logic                  hit;
   logic                  req_take;
   logic                  rsp_free;

   function automatic logic [ADDR_BITS-1:0] slot_addr(logic [LEVEL_BITS-1:0] lvl,
                                                      logic [POS_BITS-1:0]   pos);
      slot_addr = ADDR_BITS'(lvl) * ADDR_BITS'(LEVEL_DEPTH) + ADDR_BITS'(pos);
   endfunction

   function automatic logic is_eligible(flags_type f, logic [LEVEL_BITS-1:0] lvl);
      logic base_ok;
      base_ok = f.has_file && f.in_progress && f.wants_data;
      if (lvl == LEVEL_BITS'(NUM_LEVELS - 1)) begin
         is_eligible = base_ok && (f.buffers_filled == 2'd0);
      end else begin
         is_eligible = base_ok && (f.buffers_filled < 2'd2);
      end
   endfunction

   assign req_port.ready = (state_ff == ST_IDLE);
   assign req_take       = req_port.valid && (state_ff == ST_IDLE);
   assign rsp_free       = !rsp_valid_ff || rsp_port.ready;
   assign rsp_port.valid = rsp_valid_ff;
   assign rsp_port.word  = rsp_word_ff;

   assign scan_up       = (op_cmd_ff != CMD_SELECT);
   assign scan_lvl      = scan_up ? scan_k_ff[LEVEL_BITS-1:0]
                                  : LEVEL_BITS'(NUM_LEVELS - 1) - scan_k_ff[LEVEL_BITS-1:0];
   assign scan_down_pos = cur_count - COUNT_BITS'(1) - scan_j_ff;
   assign scan_pos      = scan_up ? scan_j_ff[POS_BITS-1:0] : scan_down_pos[POS_BITS-1:0];

   always_comb begin
      case (state_ff)
         ST_ENQ:              cur_lvl = op_level_ff;
         ST_SH_RD, ST_SH_WR:  cur_lvl = shift_lvl_ff;
         default:             cur_lvl = scan_lvl;
      endcase
   end

   assign cur_count = level_count_ff[cur_lvl];

   always_comb begin
      if (op_cmd_ff == CMD_SELECT) begin
         hit = rd_valid_ff && is_eligible(rd_word_ff.flags, rd_lvl_ff);
      end else begin
         hit = rd_valid_ff && (rd_word_ff.handle == op_handle_ff);
      end
   end

   always_comb begin
      state_in      = state_ff;
      op_cmd_in     = op_cmd_ff;
      op_handle_in  = op_handle_ff;
      op_level_in   = op_level_ff;
      op_flags_in   = op_flags_ff;
      scan_k_in     = scan_k_ff;
      scan_j_in     = scan_j_ff;
      rd_valid_in   = 1'b0;
      rd_lvl_in     = rd_lvl_ff;
      rd_pos_in     = rd_pos_ff;
      shift_lvl_in  = shift_lvl_ff;
      shift_pos_in  = shift_pos_ff;
      res_status_in = res_status_ff;
      res_handle_in = res_handle_ff;
      res_level_in  = res_level_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_port.ready;
      rsp_word_in   = rsp_word_ff;
      mem_we        = 1'b0;
      mem_waddr     = slot_addr(shift_lvl_ff, shift_pos_ff);
      mem_wdata     = rd_word_ff;
      mem_raddr     = slot_addr(scan_lvl, scan_pos);
      count_we      = 1'b0;
      count_wdata   = cur_count;

      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               op_cmd_in    = req_port.word.command;
               op_handle_in = HANDLE_BITS'(req_port.word.handle);
               if (32'(req_port.word.priority_req) > NUM_LEVELS - 1) begin
                  op_level_in = LEVEL_BITS'(NUM_LEVELS - 1);
               end else begin
                  op_level_in = LEVEL_BITS'(req_port.word.priority_req);
               end
               op_flags_in.has_file       = req_port.word.has_file;
               op_flags_in.in_progress    = req_port.word.in_progress;
               op_flags_in.wants_data     = req_port.word.wants_data;
               op_flags_in.buffers_filled = req_port.word.buffers_filled;
               res_status_in = STS_DONE;
               res_handle_in = '0;
               res_level_in  = '0;
               scan_k_in     = '0;
               scan_j_in     = '0;
               if (req_port.word.command == CMD_ENQUEUE) begin
                  state_in = ST_ENQ;
               end else begin
                  state_in = ST_SCAN;
               end
            end
         end
         ST_ENQ: begin
            if (cur_count >= COUNT_BITS'(LEVEL_DEPTH)) begin
               res_status_in = STS_LEVEL_FULL;
            end else begin
               mem_we      = 1'b1;
               mem_waddr   = slot_addr(op_level_ff, cur_count[POS_BITS-1:0]);
               mem_wdata   = '{flags: op_flags_ff, handle: op_handle_ff};
               count_we    = 1'b1;
               count_wdata = cur_count + COUNT_BITS'(1);
            end
            state_in = ST_FINISH;
         end
         ST_SCAN: begin
            if (hit) begin
               case (op_cmd_ff)
                  CMD_REMOVE: begin
                     shift_lvl_in = rd_lvl_ff;
                     shift_pos_in = rd_pos_ff;
                     state_in     = ST_SH_RD;
                  end
                  CMD_UPDATE: begin
                     mem_we    = 1'b1;
                     mem_waddr = slot_addr(rd_lvl_ff, rd_pos_ff);
                     mem_wdata = '{flags: op_flags_ff, handle: rd_word_ff.handle};
                     state_in  = ST_FINISH;
                  end
                  default: begin
                     res_handle_in = 8'(rd_word_ff.handle);
                     res_level_in  = 2'(rd_lvl_ff);
                     state_in      = ST_FINISH;
                  end
               endcase
            end else if (scan_k_ff < STEP_BITS'(NUM_LEVELS)) begin
               if (scan_j_ff < cur_count) begin
                  rd_valid_in = 1'b1;
                  rd_lvl_in   = scan_lvl;
                  rd_pos_in   = scan_pos;
                  scan_j_in   = scan_j_ff + COUNT_BITS'(1);
               end else begin
                  scan_k_in = scan_k_ff + STEP_BITS'(1);
                  scan_j_in = '0;
               end
            end else if (!rd_valid_ff) begin
               if (op_cmd_ff == CMD_SELECT) begin
                  res_status_in = STS_NONE_READY;
               end else begin
                  res_status_in = STS_NOT_FOUND;
               end
               state_in = ST_FINISH;
            end
         end
         ST_SH_RD: begin
            if (COUNT_BITS'(shift_pos_ff) + COUNT_BITS'(1) < cur_count) begin
               mem_raddr = slot_addr(shift_lvl_ff, POS_BITS'(shift_pos_ff + POS_BITS'(1)));
               state_in  = ST_SH_WR;
            end else begin
               count_we    = 1'b1;
               count_wdata = cur_count - COUNT_BITS'(1);
               state_in    = ST_FINISH;
            end
         end
         ST_SH_WR: begin
            mem_we       = 1'b1;
            shift_pos_in = shift_pos_ff + POS_BITS'(1);
            state_in     = ST_SH_RD;
         end
         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_word_in  = '{status: res_status_ff, selected_handle: res_handle_ff,
                                selected_level: res_level_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         entry_mem[mem_waddr] <= mem_wdata;
      end
      rd_word_ff <= entry_mem[mem_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LEVELS; i++) begin
            level_count_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (count_we) begin
            level_count_ff[cur_lvl] <= count_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      op_cmd_ff     <= op_cmd_in;
      op_handle_ff  <= op_handle_in;
      op_level_ff   <= op_level_in;
      op_flags_ff   <= op_flags_in;
      scan_k_ff     <= scan_k_in;
      scan_j_ff     <= scan_j_in;
      rd_lvl_ff     <= rd_lvl_in;
      rd_pos_ff     <= rd_pos_in;
      shift_lvl_ff  <= shift_lvl_in;
      shift_pos_ff  <= shift_pos_in;
      res_status_ff <= res_status_in;
      res_handle_ff <= res_handle_in;
      res_level_ff  <= res_level_in;
      rsp_word_ff   <= rsp_word_in;
   end

endmodule

`default_nettype wire
